// File: src/mpr_pkg.sv
`default_nettype none

package mpr_pkg;

    // Frame store geometry
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);

    // Datapath widths
    localparam int PIX_W      = 8;
    localparam int PROD_W     = 2 * PIX_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_HIGH = 1'b1;

    // Register reset values
    localparam logic [PIX_W-1:0] TARGET_LOW_RST  = 8'd0;
    localparam logic [PIX_W-1:0] TARGET_HIGH_RST = 8'd255;
    localparam logic [PIX_W-1:0] MIN_CLEAR       = 8'd255;
    localparam logic [PIX_W-1:0] MAX_CLEAR       = 8'd0;

    // Input item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] pixel_in;
        logic             first_pixel;
    } pix_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_pixel;
        logic             read_error;
    } res_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// File: src/mpr_frame_ram.sv
`default_nettype none

module mpr_frame_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/mpr_divider.sv
`default_nettype none

module mpr_divider
    import mpr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [PIX_W-1:0]  divisor,
    output logic                   done,
    output logic      [PROD_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [PIX_W-1:0]  rem_reg, rem_next;
    logic [PIX_W-1:0]  den_reg, den_next;
    logic [PIX_W:0]    rem_shift;
    logic              fits;

    // One restoring step per cycle, MSB first
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        rem_shift = {rem_reg, quo_reg[PROD_W-1]};
        fits      = (rem_shift >= {1'b0, den_reg});
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[PROD_W-2:0], fits};
            rem_next = fits ? PIX_W'(rem_shift - {1'b0, den_reg}) : rem_shift[PIX_W-1:0];
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg - STEP_W'(1);
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Hold operands and partial results
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: src/minmax_pixel_rescale.sv
`default_nettype none

// Channel   Direction  Handshake            Transaction
// pix       in         pix_valid/pix_stall  load a pixel or request the next rescaled one
// res       out        res_valid/res_stall  one rescaled pixel per read request
// cfg       in         cfg_valid/cfg_ready  write target_low (0) or target_high (1)
//
// A load never leaves the idle state, so loads stream at one pixel per clock.
// A read holds pix_stall from acceptance until it is emitted: a frame store
// read, a multiply, the bit-serial divider, then the emit.
// A read past the end goes straight to the emit; a read of a constant image skips the divider.
// The frame store is not cleared at reset; only entries below the count are read.
// The output register lets the next item in while a result waits on res_stall.

module minmax_pixel_rescale
    import mpr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pix_valid,
    output logic                        pix_stall,
    input  wire pix_item_t              pix_data,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output res_item_t                   res_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [PIX_W-1:0]       cfg_data
);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [PIX_W-1:0] min_reg, min_next;
    logic [PIX_W-1:0] max_reg, max_next;
    logic [PIX_W-1:0] tlow_reg, tlow_next;
    logic [PIX_W-1:0] thigh_reg, thigh_next;
    logic             out_valid_reg, out_valid_next;
    res_item_t        out_data_reg, out_data_next;
    res_item_t        pend_reg, pend_next;
    logic             last_reg, last_next;
    logic             inv_reg, inv_next;

    logic             accept;
    logic [CNT_W-1:0] eff_count, eff_ptr;
    logic [PIX_W-1:0] eff_min, eff_max;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    logic [PIX_W-1:0]  den, off, span, quo8;
    logic [PROD_W-1:0] prod, div_q;
    logic              div_start, div_done;
    logic [PIX_W:0]    avg_sum;

    mpr_frame_ram #(
        .DEPTH  (MAX_PIXELS),
        .WIDTH  (PIX_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (pix_data.pixel_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mpr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (den),
        .done     (div_done),
        .quotient (div_q)
    );

    assign pix_stall = (state_reg != ST_IDLE);
    assign accept    = pix_valid && !pix_stall;
    assign cfg_ready = 1'b1;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    // Apply a new-image clear before the item acts
    assign eff_count = pix_data.first_pixel ? '0 : count_reg;
    assign eff_ptr   = pix_data.first_pixel ? '0 : ptr_reg;
    assign eff_min   = pix_data.first_pixel ? MIN_CLEAR : min_reg;
    assign eff_max   = pix_data.first_pixel ? MAX_CLEAR : max_reg;

    assign ram_waddr = eff_count[ADDR_W-1:0];
    assign ram_raddr = eff_ptr[ADDR_W-1:0];

    // Map the fetched pixel: clamp the offset, form the product
    assign den     = max_reg - min_reg;
    assign off     = (ram_rdata < min_reg) ? '0 :
                     ((ram_rdata - min_reg) > den) ? den : PIX_W'(ram_rdata - min_reg);
    assign span    = (tlow_reg <= thigh_reg) ? PIX_W'(thigh_reg - tlow_reg)
                                             : PIX_W'(tlow_reg - thigh_reg);
    assign prod    = PROD_W'(off) * PROD_W'(span);
    assign avg_sum = {1'b0, tlow_reg} + {1'b0, thigh_reg};
    assign quo8    = div_q[PIX_W-1:0];

    // Sequence one item, drive the output register
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        tlow_next      = tlow_reg;
        thigh_next     = thigh_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pend_next      = pend_reg;
        last_next      = last_reg;
        inv_next       = inv_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;

        // Drop the result once taken
        if (out_valid_reg && !res_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Write a target register
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARGET_LOW:  tlow_next  = cfg_data;
                CFG_TARGET_HIGH: thigh_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    count_next = eff_count;
                    ptr_next   = eff_ptr;
                    min_next   = eff_min;
                    max_next   = eff_max;
                    if (pix_data.mode == MODE_LOAD)
                    begin
                        if (eff_count != CNT_W'(MAX_PIXELS))
                        begin
                            ram_we     = 1'b1;
                            count_next = eff_count + CNT_W'(1);
                            if (pix_data.pixel_in < eff_min)
                            begin
                                min_next = pix_data.pixel_in;
                            end
                            if (pix_data.pixel_in > eff_max)
                            begin
                                max_next = pix_data.pixel_in;
                            end
                        end
                    end
                    else if (eff_ptr >= eff_count)
                    begin
                        pend_next.pixel_out  = '0;
                        pend_next.last_pixel = 1'b0;
                        pend_next.read_error = 1'b1;
                        state_next           = ST_EMIT;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ptr_next   = eff_ptr + CNT_W'(1);
                        last_next  = ((eff_ptr + CNT_W'(1)) == eff_count);
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                pend_next.last_pixel = last_reg;
                pend_next.read_error = 1'b0;
                inv_next             = (tlow_reg > thigh_reg);
                if (min_reg >= max_reg)
                begin
                    pend_next.pixel_out = avg_sum[PIX_W:1];
                    state_next          = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    pend_next.pixel_out = inv_reg ? PIX_W'(tlow_reg - quo8)
                                                  : PIX_W'(tlow_reg + quo8);
                    state_next          = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ptr_reg       <= '0;
            min_reg       <= MIN_CLEAR;
            max_reg       <= MAX_CLEAR;
            tlow_reg      <= TARGET_LOW_RST;
            thigh_reg     <= TARGET_HIGH_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            tlow_reg      <= tlow_next;
            thigh_reg     <= thigh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        pend_reg     <= pend_next;
        last_reg     <= last_next;
        inv_reg      <= inv_next;
    end

endmodule

`default_nettype wire

// File: src/mpr_checker.sv
`default_nettype none

module mpr_checker
    import mpr_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      pix_valid,
    input wire logic      pix_stall,
    input wire pix_item_t pix_data,
    input wire logic      res_valid,
    input wire logic      res_stall,
    input wire res_item_t res_data
);

    // No result is offered once reset has been seen at an edge
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !res_valid)
        else $error("result valid during reset");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // A load never creates a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && pix_data.mode == MODE_LOAD && !res_valid |=> !res_valid)
        else $error("result after a load");

    // A read request blocks the input while it is processed
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && pix_data.mode == MODE_READ |=> pix_stall)
        else $error("input open right after a read request");

endmodule

bind minmax_pixel_rescale mpr_checker u_mpr_checker (.*);

`default_nettype wire
